### rtl/ransac_round_count_macros.svh
// Assertion helpers for the round count block.
// Each macro expects clk and rst_n in scope.
`ifndef RANSAC_ROUND_COUNT_MACROS_SVH
`define RANSAC_ROUND_COUNT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rrc_pkg.sv
// ---------------------------------------------------------------------------
// rrc_pkg
// Shared constants for the adaptive RANSAC round count block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rrc_pkg;

  typedef logic [1:0] status_t;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_SATURATED = 2'd1;
  localparam status_t ST_INVALID   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CONFIDENCE  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_SIZE = 2'd1;

  // Fixed-point constants
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
  localparam logic [30:0] ROUND_MAX  = 31'h7FFF_FFFF;
  localparam logic [37:0] LOG_SPAN   = 38'h20_0000_0000;  // 32.0 in Q6.32
  localparam logic [32:0] CONF_RESET = 33'd4252017623;
  localparam logic [3:0]  SS_RESET   = 4'd8;

endpackage

### rtl/ransac_round_count.sv
// ---------------------------------------------------------------------------
// ransac_round_count
// Adaptive RANSAC iteration count from inlier and point counts.
// ---------------------------------------------------------------------------
// Usage: one beat on the in_ channel (inlier and point count) yields one
// beat on the out_ channel (round count and status). The cfg_ channel
// writes confidence (index 0) and sample size (index 1); it is always ready;
// the user writes it only while the block is idle, which the block does not enforce.
// Flow: the block works on one item at a time and drops in_ready while
// busy. A shared restoring divider (one quotient bit a cycle, 33+COUNT_BITS
// or 38 bits, whichever is more) and one 33x32 multiplier do all the work.
// Each of the s sample factors is a multiply then a divide; each of the two
// logs normalizes its operand, then squares and evaluates once per fraction
// bit; a final divide gives the round count. Invalid or saturated-confidence
// items go straight to the finish state.
// Reset: rst_n (synchronous, active low) returns to idle, drops out_valid
// and loads confidence 4252017623 and sample size 8.
// Stall: the result sits in an output register; a new item is accepted
// while it waits, and the next result holds until out_ready takes the first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ransac_round_count_macros.svh"
module ransac_round_count
  import rrc_pkg::*;
#(
  parameter int MAX_SAMPLE = 8,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_inlier_count,
  input  logic [19:0] in_point_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_round_count,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_data
);

  localparam int CB = COUNT_BITS;
  localparam int DW = (33 + CB > 38) ? 33 + CB : 38;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PMUL  = 4'd1;
  localparam logic [3:0] S_PLOAD = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_LNORM = 4'd5;
  localparam logic [3:0] S_LSQ   = 4'd6;
  localparam logic [3:0] S_LEV   = 4'd7;
  localparam logic [3:0] S_LDONE = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [32:0]   conf_r;
  logic [3:0]    ss_r;
  logic [CB-1:0] n_r, p_r;
  logic [4:0]    s_r, i_r;
  logic [32:0]   q_r;
  logic [64:0]   prod_r;
  logic [DW-1:0] dvd_r;
  logic [36:0]   dvs_r, rem_r;
  logic          div_final_r;
  logic [5:0]    cnt_r;
  logic [32:0]   x_r;
  logic [5:0]    e_r;
  logic [31:0]   m_r, frac_r;
  logic          log_b_r;
  logic [37:0]   dc_r;
  logic [30:0]   res_round_r;
  status_t       res_status_r;
  logic          out_valid_r;
  logic [30:0]   out_round_r;
  status_t       out_status_r;

  // Input decode
  logic [31:0]   inl_ext, pts_ext;
  logic [CB-1:0] in_n, in_p;
  logic [4:0]    s_in;
  assign inl_ext = 32'(in_inlier_count);
  assign pts_ext = 32'(in_point_count);
  assign in_n    = inl_ext[CB-1:0];
  assign in_p    = pts_ext[CB-1:0];
  assign s_in    = ({1'b0, ss_r} > 5'(MAX_SAMPLE)) ? 5'(MAX_SAMPLE) : {1'b0, ss_r};

  // Sample factor operands
  logic [CB-1:0] i_ext, num, den;
  assign i_ext = CB'(i_r);
  assign num   = (n_r > i_ext) ? n_r - i_ext : '0;
  assign den   = p_r - i_ext;

  // Shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  always_comb begin
    if (state_r == S_PMUL) begin
      mul_a = q_r;
      mul_b = 32'(num);
    end else begin
      mul_a = {1'b0, m_r};
      mul_b = m_r;
    end
  end
  assign mul_p = {32'd0, mul_a} * {33'd0, mul_b};

  // Restoring divider step
  logic [37:0]   rem_sh;
  logic          div_ge;
  logic [36:0]   rem_step;
  logic [DW-1:0] dvd_step;
  assign rem_sh   = {rem_r, dvd_r[DW-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs_r};
  assign rem_step = div_ge ? 37'(rem_sh - {1'b0, dvs_r}) : rem_sh[36:0];
  assign dvd_step = {dvd_r[DW-2:0], div_ge};

  // Log squaring evaluation and log distance from 32.0
  logic [32:0] sq;
  logic [37:0] log_d;
  assign sq    = prod_r[63:31];
  assign log_d = LOG_SPAN - {e_r, frac_r};

  logic [31:0] qt_hi;
  assign qt_hi = 32'(dvd_step >> 31);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_n > in_p || in_p < CB'(s_in)) state_nxt = S_FIN;
          else if (conf_r[32])                 state_nxt = S_FIN;
          else if (s_in == 5'd0)               state_nxt = S_CHK;
          else                                 state_nxt = S_PMUL;
        end
      end
      S_PMUL:  state_nxt = S_PLOAD;
      S_PLOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == 6'd0) begin
          if (div_final_r)            state_nxt = S_FIN;
          else if (i_r + 5'd1 == s_r) state_nxt = S_CHK;
          else                        state_nxt = S_PMUL;
        end
      end
      S_CHK: begin
        if (q_r == 33'd0 || q_r[32]) state_nxt = S_FIN;
        else                         state_nxt = S_LNORM;
      end
      S_LNORM: if (x_r[32]) state_nxt = S_LSQ;
      S_LSQ:   state_nxt = S_LEV;
      S_LEV:   state_nxt = (cnt_r == 6'd0) ? S_LDONE : S_LSQ;
      S_LDONE: state_nxt = log_b_r ? S_DIV : S_LNORM;
      S_FIN:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      conf_r      <= CONF_RESET;
      ss_r        <= SS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CONFIDENCE)  conf_r <= cfg_data;
        if (cfg_index == CFG_SAMPLE_SIZE) ss_r   <= cfg_data[3:0];
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready)                                   out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        n_r   <= in_n;
        p_r   <= in_p;
        s_r   <= s_in;
        i_r   <= 5'd0;
        q_r   <= ONE_Q32;
        div_final_r <= 1'b0;
        if (in_n > in_p || in_p < CB'(s_in)) begin
          res_round_r  <= '0;
          res_status_r <= ST_INVALID;
        end else begin
          res_round_r  <= ROUND_MAX;
          res_status_r <= ST_SATURATED;
        end
      end
      S_PMUL: prod_r <= mul_p;
      S_PLOAD: begin
        dvd_r <= prod_r[DW-1:0];
        dvs_r <= 37'(den);
        rem_r <= '0;
        cnt_r <= 6'(DW - 1);
      end
      S_DIV: begin
        dvd_r <= dvd_step;
        rem_r <= rem_step;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (div_final_r) begin
            if (qt_hi != 32'd0) begin
              res_round_r  <= ROUND_MAX;
              res_status_r <= ST_SATURATED;
            end else begin
              res_round_r  <= dvd_step[30:0];
              res_status_r <= ST_OK;
            end
          end else begin
            q_r <= dvd_step[32:0];
            i_r <= i_r + 5'd1;
          end
        end
      end
      S_CHK: begin
        if (q_r[32]) begin
          res_round_r  <= '0;
          res_status_r <= ST_OK;
        end
        x_r     <= ONE_Q32 - conf_r;
        e_r     <= 6'd32;
        log_b_r <= 1'b0;
      end
      S_LNORM: begin
        if (x_r[32]) begin
          m_r    <= x_r[32:1];
          frac_r <= '0;
          cnt_r  <= 6'd31;
        end else begin
          x_r <= {x_r[31:0], 1'b0};
          e_r <= e_r - 6'd1;
        end
      end
      S_LSQ: prod_r <= mul_p;
      S_LEV: begin
        frac_r <= {frac_r[30:0], sq[32]};
        m_r    <= sq[32] ? sq[32:1] : sq[31:0];
        cnt_r  <= cnt_r - 6'd1;
      end
      S_LDONE: begin
        if (!log_b_r) begin
          dc_r    <= log_d;
          x_r     <= ONE_Q32 - q_r;
          e_r     <= 6'd32;
          log_b_r <= 1'b1;
        end else begin
          dvd_r       <= DW'(dc_r);
          dvs_r       <= (log_d[36:0] == 37'd0) ? 37'd1 : log_d[36:0];
          rem_r       <= '0;
          cnt_r       <= 6'(DW - 1);
          div_final_r <= 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_round_r  <= res_round_r;
          out_status_r <= res_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_round_count = out_round_r;
  assign out_status      = out_status_r;

  `RRC_ASSERT_NOW(a_invalid_zero, out_valid_r && out_status_r == ST_INVALID, out_round_r == 31'd0, "invalid result carries a nonzero count")
  `RRC_ASSERT_NOW(a_sat_max, out_valid_r && out_status_r == ST_SATURATED, out_round_r == ROUND_MAX, "saturated result below maximum")
  `RRC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `RRC_ASSERT_NOW(a_norm_bounded, state_r == S_LNORM, x_r != 33'd0, "log operand is zero")

endmodule

### dv/testbench.sv
// ---------------------------------------------------------------------------
// RANSAC round count testbench
// Sends inlier/point count beats through several confidence and sample size
// settings. A scoreboard predicts each round count and status in fixed
// point, then checks results in order as they leave the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench
  import rrc_pkg::*;
;

  localparam int SAMPLE_CAP = 8;
  localparam logic [63:0] ONE = 64'h1_0000_0000;
  localparam logic [63:0] SPAN = 64'd32 << 32;

  typedef struct packed {
    logic [30:0] rounds;
    status_t     status;
  } round_beat_t;

  // Round count predictor and in-order result store
  class round_scoreboard;
    logic [32:0] confidence;
    logic [3:0]  sample_size;
    round_beat_t pending[$];
    int          errors;

    function new();
      confidence  = CONF_RESET;
      sample_size = SS_RESET;
      errors      = 0;
    endfunction

    // log2(x) with 32 fraction bits, x in [1, 2^32]
    function logic [63:0] log2_fx(logic [63:0] x);
      int unsigned ex;
      logic [63:0] mant, frac;
      ex   = 0;
      frac = 0;
      if (x == 0) return 0;
      while (ex < 63 && (x >> (ex + 1)) != 0) ex++;
      mant = (ex >= 31) ? x >> (ex - 31) : x << (31 - ex);
      for (int k = 0; k < 32; k++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= ONE) begin
          frac[0] = 1'b1;
          mant = mant >> 1;
        end
      end
      return (64'(ex) << 32) | frac;
    endfunction

    function void note_counts(logic [19:0] inl, logic [19:0] pts);
      logic [63:0] n, p, s, q, num, den, dc, dq, r;
      round_beat_t exp_beat;
      n = 64'(inl);
      p = 64'(pts);
      s = (sample_size > SAMPLE_CAP) ? 64'(SAMPLE_CAP) : 64'(sample_size);
      q = ONE;
      if (n > p || p < s) begin
        exp_beat = '{rounds: '0, status: ST_INVALID};
      end else if (confidence >= ONE_Q32) begin
        exp_beat = '{rounds: ROUND_MAX, status: ST_SATURATED};
      end else begin
        for (logic [63:0] i = 0; i < s; i++) begin
          num = (n > i) ? n - i : 64'd0;
          den = p - i;
          if (den == 0) den = 1;
          q = (q * num) / den;
        end
        if (q == 0) begin
          exp_beat = '{rounds: ROUND_MAX, status: ST_SATURATED};
        end else if (q >= ONE) begin
          exp_beat = '{rounds: '0, status: ST_OK};
        end else begin
          dc = SPAN - log2_fx(ONE - 64'(confidence));
          dq = SPAN - log2_fx(ONE - q);
          if (dq == 0) dq = 1;
          r = dc / dq;
          if (r > 64'(ROUND_MAX)) exp_beat = '{rounds: ROUND_MAX, status: ST_SATURATED};
          else exp_beat = '{rounds: r[30:0], status: ST_OK};
        end
      end
      pending.push_back(exp_beat);
    endfunction

    function void check_result(logic [30:0] rounds, status_t status);
      round_beat_t exp_beat;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rounds=%0d status=%0d", $realtime, rounds, status);
        errors++;
        return;
      end
      exp_beat = pending.pop_front();
      if (rounds !== exp_beat.rounds) begin
        $display("%0t: round_count expected %0d actual %0d", $realtime,
                 exp_beat.rounds, rounds);
        errors++;
      end
      if (status !== exp_beat.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_beat.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [19:0] in_inlier_count;
  logic [19:0] in_point_count;
  logic        out_valid;
  logic        out_ready;
  logic [30:0] out_round_count;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [32:0] cfg_data;

  round_scoreboard sb = new();
  bit   hold_request;
  bit   stim_done;

  ransac_round_count u_dut (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Mostly short gaps, sometimes long ones
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Note accepted counts and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_counts(in_inlier_count, in_point_count);
    if (rst_n && out_valid && out_ready) sb.check_result(out_round_count, out_status);
  end

  // Result receiver with random stalls and one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        hold_request = 1'b0;
        for (int c = 0; c < 3000; c++) @(negedge clk);
      end
      stall = gap_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!($urandom_range(0, 3) == 0)) @(negedge clk);
    end
  end

  // Valid stays up across back-to-back beats; a gap or drain drops it
  task automatic send_counts(logic [19:0] inl, logic [19:0] pts);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_inlier_count <= inl;
    in_point_count  <= pts;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [32:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CONFIDENCE) sb.confidence = value;
    else if (idx == CFG_SAMPLE_SIZE) sb.sample_size = value[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Well-formed counts most of the time, raw noise otherwise
  task automatic send_random(int count);
    logic [19:0] p, n;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        n = 20'($urandom());
        p = 20'($urandom());
        if ($urandom_range(0, 1)) p = 20'($urandom_range(0, 20));
      end else begin
        p = ($urandom_range(0, 3) == 0) ? 20'($urandom()) : 20'($urandom_range(8, 2000));
        if (p < 8) p = 20'd8;
        n = 20'($urandom_range(p / 3, p));
      end
      send_counts(n, p);
    end
  endtask

  initial begin
    logic [32:0] conf_set[8];
    logic [3:0]  ss_set[8];
    in_valid        = 1'b0;
    in_inlier_count = '0;
    in_point_count  = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_CONFIDENCE;
    cfg_data        = '0;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings
    send_counts(20'd10, 20'd5);          // more inliers than points
    send_counts(20'd3, 20'd7);           // fewer points than sample size
    send_counts(20'd0, 20'd0);
    send_counts(20'd100, 20'd100);       // certain sample
    send_counts(20'd5, 20'd100);         // fewer inliers than sample size
    send_counts(20'hFFFFF, 20'hFFFFF);
    send_counts(20'd80000, 20'hFFFFF);   // tiny q, huge quotient
    send_counts(20'hFFFFE, 20'hFFFFF);
    send_counts(20'd500, 20'd1000);
    drain();
    write_reg(CFG_CONFIDENCE, ONE_Q32);  // confidence of one
    send_counts(20'd500, 20'd1000);
    send_counts(20'd9, 20'd8);
    drain();
    write_reg(CFG_CONFIDENCE, 33'd0);
    write_reg(CFG_SAMPLE_SIZE, 33'd0);   // empty product
    send_counts(20'd0, 20'd0);
    send_counts(20'd1, 20'd9);
    drain();
    write_reg(CFG_SAMPLE_SIZE, 33'd15);  // clamped to the cap
    write_reg(CFG_CONFIDENCE, 33'hFFFF_FFFF);
    write_reg(2'd2, 33'h1_2345_6789);    // unused index
    write_reg(2'd3, 33'd3);
    send_counts(20'd7, 20'd8);
    send_counts(20'd900, 20'd1000);
    send_counts(20'd999, 20'd1000);
    drain();

    conf_set = '{CONF_RESET, 33'd0, 33'hFFFF_FFFF, ONE_Q32, 33'h8000_0000,
                 33'h1_FFFF_FFFF, 33'hF000_0000, 33'd1};
    ss_set   = '{4'd8, 4'd1, 4'd4, 4'd2, 4'd0, 4'd15, 4'd9, 4'd3};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_CONFIDENCE, (ph == 7) ? {1'b0, 32'($urandom())} : conf_set[ph]);
      write_reg(CFG_SAMPLE_SIZE, 33'(ss_set[ph]));
      if (ph == 2) hold_request = 1'b1;
      send_random(48);
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule
